/* src/svm_pkg.sv */
// svm_pkg: shared types and codes for the stack virtual machine step block.
// Holds payload structs, opcode and status codes, and sequencer state types.
// No dependencies.
package svm_pkg;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [14:0]        address;
    logic signed [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [9:0]         program_counter;
    logic signed [63:0] accumulator;
    logic [15:0]        stack_pointer;
    logic signed [63:0] exit_code;
    logic signed [63:0] read_data;
  } out_item_t;

  typedef enum logic [1:0] {
    REQ_CODE  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_EXEC  = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_EXIT  = 3'd1,
    STAT_DIVZ  = 3'd2,
    STAT_UNSUP = 3'd3,
    STAT_BADOP = 3'd4,
    STAT_HALT  = 3'd5,
    STAT_FAULT = 3'd6
  } status_t;

  typedef enum logic [5:0] {
    OP_IMM, OP_LC, OP_LI, OP_SC, OP_SI, OP_PUSH, OP_JMP, OP_JEZ, OP_JNZ, OP_CALL,
    OP_ADJ, OP_ENT, OP_LEV, OP_LAA, OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE,
    OP_LT, OP_LE, OP_GT, OP_GE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
    OP_OPEN, OP_CLOS, OP_READ, OP_PRTF, OP_MALC, OP_MSET, OP_MCMP, OP_EXIT
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HOSTRD, S_FETCH, S_DECODE, S_OPND, S_POP, S_POP2, S_TOP,
    S_LOAD0, S_LOAD1, S_STORE1, S_MULDIV, S_RESP
  } vm_state_t;

  typedef enum logic [1:0] {
    MD_MUL,
    MD_DIV,
    MD_MOD
  } md_op_t;

  typedef enum logic [2:0] {
    MDS_IDLE, MDS_ABSA, MDS_ABSB, MDS_RUN, MDS_FIX, MDS_DONE
  } md_state_t;

  typedef struct packed {
    logic        start;
    md_op_t      op;
    logic [63:0] a;
    logic [63:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } md_rsp_t;

  localparam int unsigned MD_STEPS = 64;

endpackage

/* src/svm_ram.sv */
// svm_ram: single-port 64-bit word memory with byte enables, registered read.
// Depends on nothing.
module svm_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [7:0]    be,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [63:0]   wdata,
  output logic [63:0]   rdata
);

  logic [63:0] mem_r [DEPTH];
  logic [63:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < 8; i++) begin
        if (be[i]) begin
          mem_r[addr][8*i +: 8] <= wdata[8*i +: 8];
        end
      end
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/svm_muldiv.sv */
// svm_muldiv: shared 64-bit multiply / signed divide / modulo unit, one bit per cycle.
// One 65-bit adder serves operand negation, shift-add and restoring subtract.
// Depends on svm_pkg.
module svm_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  svm_pkg::md_req_t req,
  output svm_pkg::md_rsp_t rsp
);

  svm_pkg::md_state_t st_r, st_nxt;
  svm_pkg::md_op_t    op_r, op_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] x_r, x_nxt, y_r, y_nxt, acc_r, acc_nxt, res_r, res_nxt;
  logic        negq_r, negq_nxt, negr_r, negr_nxt;

  logic [63:0] opa, opb, rem_sh;
  logic        sub;
  logic [64:0] sum;

  assign sum    = {1'b0, opa} + {1'b0, opb ^ {64{sub}}} + 65'(sub);
  assign rem_sh = {acc_r[62:0], x_r[63]};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      svm_pkg::MDS_IDLE: begin
        if (req.start) begin
          st_nxt = (req.op == svm_pkg::MD_MUL) ? svm_pkg::MDS_RUN : svm_pkg::MDS_ABSA;
        end
      end
      svm_pkg::MDS_ABSA: st_nxt = svm_pkg::MDS_ABSB;
      svm_pkg::MDS_ABSB: st_nxt = svm_pkg::MDS_RUN;
      svm_pkg::MDS_RUN: begin
        if (cnt_r == 6'(svm_pkg::MD_STEPS - 1)) st_nxt = svm_pkg::MDS_FIX;
      end
      svm_pkg::MDS_FIX:  st_nxt = svm_pkg::MDS_DONE;
      svm_pkg::MDS_DONE: st_nxt = svm_pkg::MDS_IDLE;
      default:           st_nxt = svm_pkg::MDS_IDLE;
    endcase
  end

  always_comb begin
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    negq_nxt = negq_r;
    negr_nxt = negr_r;
    opa      = '0;
    opb      = '0;
    sub      = 1'b0;
    case (st_r)
      svm_pkg::MDS_IDLE: begin
        if (req.start) begin
          op_nxt   = req.op;
          x_nxt    = req.a;
          y_nxt    = req.b;
          acc_nxt  = '0;
          cnt_nxt  = '0;
          negq_nxt = req.a[63] ^ req.b[63];
          negr_nxt = req.a[63];
        end
      end
      svm_pkg::MDS_ABSA: begin
        opb = x_r;
        sub = 1'b1;
        if (x_r[63]) x_nxt = sum[63:0];
      end
      svm_pkg::MDS_ABSB: begin
        opb = y_r;
        sub = 1'b1;
        if (y_r[63]) y_nxt = sum[63:0];
      end
      svm_pkg::MDS_RUN: begin
        cnt_nxt = cnt_r + 6'd1;
        if (op_r == svm_pkg::MD_MUL) begin
          opa = acc_r;
          opb = x_r;
          if (y_r[0]) acc_nxt = sum[63:0];
          x_nxt = {x_r[62:0], 1'b0};
          y_nxt = {1'b0, y_r[63:1]};
        end else begin
          // restoring step: carry out set means no borrow
          opa = rem_sh;
          opb = y_r;
          sub = 1'b1;
          acc_nxt = sum[64] ? sum[63:0] : rem_sh;
          x_nxt   = {x_r[62:0], sum[64]};
        end
      end
      svm_pkg::MDS_FIX: begin
        sub = 1'b1;
        case (op_r)
          svm_pkg::MD_MUL: res_nxt = acc_r;
          svm_pkg::MD_DIV: begin
            opb     = x_r;
            res_nxt = negq_r ? sum[63:0] : x_r;
          end
          default: begin
            opb     = acc_r;
            res_nxt = negr_r ? sum[63:0] : acc_r;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= svm_pkg::MDS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    op_r   <= op_nxt;
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
  end

  assign rsp.done   = (st_r == svm_pkg::MDS_DONE);
  assign rsp.result = res_r;

endmodule

/* src/stack_vm_step.sv */
// stack_vm_step: top level of the accumulator-and-stack virtual machine.
// Sequencer, architectural registers, config port; code and data RAMs (svm_ram)
// and the shared multiply/divide unit (svm_muldiv). Depends on svm_pkg, svm_ram and svm_muldiv.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_data): one request per transfer:
//    load code word, write data word, execute one instruction, read data word.
//  - Result channel (out_valid/out_stall/out_data): exactly one result per
//    request, held stable while out_stall is high.
//  - APB-style config port: start_address at byte 0, stack_top at byte 4.
//    Write only while idle; pready is tied high.
//  - One request at a time; in_stall is high from transfer until the result
//    is taken. A host read passes through S_HOSTRD. Instructions: fetch +
//    decode, plus a further state for each extra code or data RAM access
//    (single-port RAMs set this); MUL, and DIV/MOD with a nonzero divisor,
//    wait in S_MULDIV on the bit-serial shared unit.
//  - Reset: pc = 0, acc = 0, sp = frame = 32768, not halted. Memories are
//    not cleared; they must be written before read, unchecked by the block.
//  - A trapping instruction commits nothing and halts the machine; later
//    execute requests report halted until start_address is rewritten.
module stack_vm_step #(
  parameter int CODE_WORDS = 1024,
  parameter int DATA_WORDS = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  svm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output svm_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW  = $clog2(CODE_WORDS);
  localparam int DW  = $clog2(DATA_WORDS);
  localparam int PCW = (CW + 1 > 10) ? CW + 1 : 10;
  localparam logic [63:0] CODE_LIM   = 64'(CODE_WORDS);
  localparam logic [63:0] WORD_LIM   = 64'(DATA_WORDS);
  localparam logic [63:0] DATA_BYTES = 64'(DATA_WORDS) * 64'd8;

  // word index in range
  function automatic logic word_ok(input logic [63:0] a);
    return (a >> 3) < WORD_LIM;
  endfunction

  // n bytes from a all inside memory
  function automatic logic span_ok(input logic [63:0] a, input logic [63:0] n);
    return (a < DATA_BYTES) && ((DATA_BYTES - a) >= n);
  endfunction

  function automatic logic [DW-1:0] widx(input logic [63:0] a);
    return a[DW+2:3];
  endfunction

  function automatic logic [15:0] lane_be(input logic [2:0] off, input logic four);
    return {8'h00, (four ? 8'h0F : 8'h01)} << off;
  endfunction

  // ---- state ----
  svm_pkg::vm_state_t state_r, state_nxt;
  svm_pkg::opcode_t   op_r, op_nxt;
  svm_pkg::in_item_t  req_r, req_nxt;
  logic [9:0]     start_r, start_nxt;
  logic [15:0]    stop_r, stop_nxt;
  logic [PCW-1:0] pc_r, pc_nxt, wpc_r, wpc_nxt;
  logic [63:0]    acc_r, acc_nxt, wax_r, wax_nxt;
  logic [15:0]    sp_r, sp_nxt, wsp_r, wsp_nxt;
  logic [15:0]    bp_r, bp_nxt, wbp_r, wbp_nxt;
  logic           halt_r, halt_nxt;
  logic [63:0]    wl_r, wl_nxt;
  logic [2:0]     stat_r, stat_nxt;
  logic [63:0]    exit_r, exit_nxt;
  logic [63:0]    rd_r, rd_nxt;

  // ---- memories and shared unit ----
  logic          cm_we, cm_re;
  logic [CW-1:0] cm_addr;
  logic [63:0]   cm_wdata, cm_rdata;
  logic          dm_we, dm_re;
  logic [7:0]    dm_be;
  logic [DW-1:0] dm_addr;
  logic [63:0]   dm_wdata, dm_rdata;
  svm_pkg::md_req_t md_req;
  svm_pkg::md_rsp_t md_rsp;

  svm_ram #(.DEPTH(CODE_WORDS), .AW(CW)) u_code (
    .clk(clk), .we(cm_we), .be(8'hFF), .re(cm_re), .addr(cm_addr),
    .wdata(cm_wdata), .rdata(cm_rdata)
  );

  svm_ram #(.DEPTH(DATA_WORDS), .AW(DW)) u_data (
    .clk(clk), .we(dm_we), .be(dm_be), .re(dm_re), .addr(dm_addr),
    .wdata(dm_wdata), .rdata(dm_rdata)
  );

  svm_muldiv u_md (.clk(clk), .rst_n(rst_n), .req(md_req), .rsp(md_rsp));

  // ---- decisions shared by the sequencer and datapath ----
  logic in_xfer, cfg_wr, host_ok, pc_bad, sp_ok, bp_ok, push_ok, span1, span4;
  logic op_bad, op_unsup, pop_span, pop_split, ld_split, divz, taken;
  logic [15:0] push_a;
  svm_pkg::opcode_t op6;

  assign in_xfer   = in_valid && !in_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign host_ok   = word_ok(64'(in_data.address));
  assign pc_bad    = 64'(wpc_r) >= CODE_LIM;
  assign sp_ok     = word_ok(64'(wsp_r));
  assign bp_ok     = word_ok(64'(wbp_r));
  assign push_a    = wsp_r - 16'd8;
  assign push_ok   = word_ok(64'(push_a));
  assign span1     = span_ok(wax_r, 64'd1);
  assign span4     = span_ok(wax_r, 64'd4);
  assign op6       = svm_pkg::opcode_t'(cm_rdata[5:0]);
  assign op_bad    = cm_rdata > 64'(svm_pkg::OP_EXIT);
  assign op_unsup  = !op_bad && (op6 inside {svm_pkg::OP_OPEN,
                                             [svm_pkg::OP_READ:svm_pkg::OP_MCMP]});
  assign pop_span  = span_ok(dm_rdata, (op_r == svm_pkg::OP_SI) ? 64'd4 : 64'd1);
  assign pop_split = (op_r == svm_pkg::OP_SI) && (dm_rdata[2:0] > 3'd4);
  assign ld_split  = wax_r[2:0] > 3'd4;
  assign divz      = (wax_r == 64'd0);
  assign taken     = (op_r == svm_pkg::OP_JMP) || (op_r == svm_pkg::OP_CALL) ||
                     ((op_r == svm_pkg::OP_JEZ) && divz) ||
                     ((op_r == svm_pkg::OP_JNZ) && !divz);

  assign md_req.start = (state_r == svm_pkg::S_POP) &&
                        ((op_r == svm_pkg::OP_MUL) ||
                         (((op_r == svm_pkg::OP_DIV) || (op_r == svm_pkg::OP_MOD)) && !divz));
  assign md_req.op    = (op_r == svm_pkg::OP_MUL) ? svm_pkg::MD_MUL :
                        (op_r == svm_pkg::OP_DIV) ? svm_pkg::MD_DIV : svm_pkg::MD_MOD;
  assign md_req.a     = dm_rdata;
  assign md_req.b     = wax_r;

  // ---- sequencer next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      svm_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (in_data.req_type)
            svm_pkg::REQ_READ: state_nxt = host_ok ? svm_pkg::S_HOSTRD : svm_pkg::S_RESP;
            svm_pkg::REQ_EXEC: state_nxt = halt_r ? svm_pkg::S_RESP : svm_pkg::S_FETCH;
            default:           state_nxt = svm_pkg::S_RESP;
          endcase
        end
      end
      svm_pkg::S_FETCH: state_nxt = pc_bad ? svm_pkg::S_RESP : svm_pkg::S_DECODE;
      svm_pkg::S_DECODE: begin
        state_nxt = svm_pkg::S_RESP;
        if (!op_bad && !op_unsup) begin
          case (op6) inside
            svm_pkg::OP_IMM, [svm_pkg::OP_JMP:svm_pkg::OP_ENT], svm_pkg::OP_LAA:
              state_nxt = pc_bad ? svm_pkg::S_RESP : svm_pkg::S_OPND;
            svm_pkg::OP_LC: state_nxt = span1 ? svm_pkg::S_LOAD0 : svm_pkg::S_RESP;
            svm_pkg::OP_LI: state_nxt = span4 ? svm_pkg::S_LOAD0 : svm_pkg::S_RESP;
            svm_pkg::OP_SC, svm_pkg::OP_SI, [svm_pkg::OP_OR:svm_pkg::OP_MOD]:
              state_nxt = sp_ok ? svm_pkg::S_POP : svm_pkg::S_RESP;
            svm_pkg::OP_LEV: state_nxt = bp_ok ? svm_pkg::S_POP : svm_pkg::S_RESP;
            svm_pkg::OP_CLOS, svm_pkg::OP_EXIT:
              state_nxt = sp_ok ? svm_pkg::S_TOP : svm_pkg::S_RESP;
            default: state_nxt = svm_pkg::S_RESP;
          endcase
        end
      end
      svm_pkg::S_POP: begin
        case (op_r) inside
          svm_pkg::OP_SC, svm_pkg::OP_SI:
            state_nxt = (pop_span && pop_split) ? svm_pkg::S_STORE1 : svm_pkg::S_RESP;
          svm_pkg::OP_LEV: state_nxt = sp_ok ? svm_pkg::S_POP2 : svm_pkg::S_RESP;
          svm_pkg::OP_MUL: state_nxt = svm_pkg::S_MULDIV;
          svm_pkg::OP_DIV, svm_pkg::OP_MOD:
            state_nxt = divz ? svm_pkg::S_RESP : svm_pkg::S_MULDIV;
          default: state_nxt = svm_pkg::S_RESP;
        endcase
      end
      svm_pkg::S_LOAD0:
        state_nxt = ((op_r == svm_pkg::OP_LI) && ld_split) ? svm_pkg::S_LOAD1 : svm_pkg::S_RESP;
      svm_pkg::S_MULDIV: state_nxt = md_rsp.done ? svm_pkg::S_RESP : svm_pkg::S_MULDIV;
      svm_pkg::S_RESP:   state_nxt = out_stall ? svm_pkg::S_RESP : svm_pkg::S_IDLE;
      default:           state_nxt = svm_pkg::S_RESP;
    endcase
  end

  // ---- datapath, memory control, commit ----
  always_comb begin
    logic [127:0] lanes;
    logic [15:0]  be16;
    logic [63:0]  word;
    lanes     = '0;
    be16      = '0;
    word      = '0;
    op_nxt    = op_r;
    req_nxt   = req_r;
    start_nxt = start_r;
    stop_nxt  = stop_r;
    pc_nxt    = pc_r;
    acc_nxt   = acc_r;
    sp_nxt    = sp_r;
    bp_nxt    = bp_r;
    halt_nxt  = halt_r;
    wpc_nxt   = wpc_r;
    wax_nxt   = wax_r;
    wsp_nxt   = wsp_r;
    wbp_nxt   = wbp_r;
    wl_nxt    = wl_r;
    stat_nxt  = stat_r;
    exit_nxt  = exit_r;
    rd_nxt    = rd_r;
    cm_we     = 1'b0;
    cm_re     = 1'b0;
    cm_addr   = '0;
    cm_wdata  = in_data.value;
    dm_we     = 1'b0;
    dm_re     = 1'b0;
    dm_be     = 8'hFF;
    dm_addr   = '0;
    dm_wdata  = wax_r;

    case (state_r)
      svm_pkg::S_IDLE: begin
        if (in_xfer) begin
          req_nxt  = in_data;
          wpc_nxt  = pc_r;
          wax_nxt  = acc_r;
          wsp_nxt  = sp_r;
          wbp_nxt  = bp_r;
          stat_nxt = svm_pkg::STAT_OK;
          exit_nxt = '0;
          rd_nxt   = '0;
          case (in_data.req_type)
            svm_pkg::REQ_CODE: begin
              if (64'(in_data.address) < CODE_LIM) begin
                cm_we   = 1'b1;
                cm_addr = CW'(in_data.address);
              end else begin
                stat_nxt = svm_pkg::STAT_FAULT;
              end
            end
            svm_pkg::REQ_EXEC: begin
              if (halt_r) stat_nxt = svm_pkg::STAT_HALT;
            end
            default: begin
              if (host_ok) begin
                dm_addr  = widx(64'(in_data.address));
                dm_wdata = in_data.value;
                dm_we    = (in_data.req_type == svm_pkg::REQ_WRITE);
                dm_re    = (in_data.req_type == svm_pkg::REQ_READ);
              end else begin
                stat_nxt = svm_pkg::STAT_FAULT;
              end
            end
          endcase
        end
      end
      svm_pkg::S_HOSTRD: rd_nxt = dm_rdata;
      svm_pkg::S_FETCH: begin
        if (pc_bad) begin
          stat_nxt = svm_pkg::STAT_FAULT;
        end else begin
          cm_re   = 1'b1;
          cm_addr = wpc_r[CW-1:0];
          wpc_nxt = wpc_r + PCW'(1);
        end
      end
      svm_pkg::S_DECODE: begin
        op_nxt = op6;
        if (op_bad) begin
          stat_nxt = svm_pkg::STAT_BADOP;
          exit_nxt = '1;
        end else if (op_unsup) begin
          stat_nxt = svm_pkg::STAT_UNSUP;
        end else begin
          case (op6) inside
            svm_pkg::OP_IMM, [svm_pkg::OP_JMP:svm_pkg::OP_ENT], svm_pkg::OP_LAA: begin
              if (pc_bad) begin
                stat_nxt = svm_pkg::STAT_FAULT;
              end else begin
                cm_re   = 1'b1;
                cm_addr = wpc_r[CW-1:0];
                wpc_nxt = wpc_r + PCW'(1);
              end
            end
            svm_pkg::OP_LC, svm_pkg::OP_LI: begin
              if ((op6 == svm_pkg::OP_LC) ? span1 : span4) begin
                dm_re   = 1'b1;
                dm_addr = widx(wax_r);
              end else begin
                stat_nxt = svm_pkg::STAT_FAULT;
              end
            end
            svm_pkg::OP_SC, svm_pkg::OP_SI, [svm_pkg::OP_OR:svm_pkg::OP_MOD],
            svm_pkg::OP_CLOS, svm_pkg::OP_EXIT: begin
              if (sp_ok) begin
                dm_re   = 1'b1;
                dm_addr = widx(64'(wsp_r));
                if (!(op6 inside {svm_pkg::OP_CLOS, svm_pkg::OP_EXIT})) begin
                  wsp_nxt = wsp_r + 16'd8;
                end
              end else begin
                stat_nxt = svm_pkg::STAT_FAULT;
              end
            end
            svm_pkg::OP_PUSH: begin
              if (push_ok) begin
                dm_we   = 1'b1;
                dm_addr = widx(64'(push_a));
                wsp_nxt = push_a;
              end else begin
                stat_nxt = svm_pkg::STAT_FAULT;
              end
            end
            svm_pkg::OP_LEV: begin
              if (bp_ok) begin
                dm_re   = 1'b1;
                dm_addr = widx(64'(wbp_r));
                wsp_nxt = wbp_r + 16'd8;
              end else begin
                stat_nxt = svm_pkg::STAT_FAULT;
              end
            end
            default: ;
          endcase
        end
      end
      svm_pkg::S_OPND: begin
        case (op_r) inside
          svm_pkg::OP_IMM: wax_nxt = cm_rdata;
          [svm_pkg::OP_JMP:svm_pkg::OP_CALL]: begin
            if (taken) begin
              if (cm_rdata >= CODE_LIM) begin
                stat_nxt = svm_pkg::STAT_FAULT;
              end else if (op_r == svm_pkg::OP_CALL) begin
                if (push_ok) begin
                  dm_we    = 1'b1;
                  dm_addr  = widx(64'(push_a));
                  dm_wdata = 64'(wpc_r);
                  wsp_nxt  = push_a;
                  wpc_nxt  = cm_rdata[PCW-1:0];
                end else begin
                  stat_nxt = svm_pkg::STAT_FAULT;
                end
              end else begin
                wpc_nxt = cm_rdata[PCW-1:0];
              end
            end
          end
          svm_pkg::OP_ADJ: wsp_nxt = wsp_r + {cm_rdata[12:0], 3'b000};
          svm_pkg::OP_ENT: begin
            if (push_ok) begin
              dm_we    = 1'b1;
              dm_addr  = widx(64'(push_a));
              dm_wdata = 64'(wbp_r);
              wbp_nxt  = push_a;
              wsp_nxt  = push_a - {cm_rdata[12:0], 3'b000};
            end else begin
              stat_nxt = svm_pkg::STAT_FAULT;
            end
          end
          svm_pkg::OP_LAA: wax_nxt = 64'(wbp_r) + {cm_rdata[60:0], 3'b000};
          default: ;
        endcase
      end
      svm_pkg::S_POP: begin
        wl_nxt = dm_rdata;
        case (op_r) inside
          svm_pkg::OP_SC, svm_pkg::OP_SI: begin
            if (pop_span) begin
              lanes    = {64'd0, wax_r} << {dm_rdata[2:0], 3'b000};
              be16     = lane_be(dm_rdata[2:0], op_r == svm_pkg::OP_SI);
              dm_we    = 1'b1;
              dm_addr  = widx(dm_rdata);
              dm_be    = be16[7:0];
              dm_wdata = lanes[63:0];
            end else begin
              stat_nxt = svm_pkg::STAT_FAULT;
            end
          end
          svm_pkg::OP_LEV: begin
            if (sp_ok) begin
              dm_re   = 1'b1;
              dm_addr = widx(64'(wsp_r));
              wsp_nxt = wsp_r + 16'd8;
            end else begin
              stat_nxt = svm_pkg::STAT_FAULT;
            end
          end
          svm_pkg::OP_OR:  wax_nxt = dm_rdata | wax_r;
          svm_pkg::OP_XOR: wax_nxt = dm_rdata ^ wax_r;
          svm_pkg::OP_AND: wax_nxt = dm_rdata & wax_r;
          svm_pkg::OP_EQ:  wax_nxt = 64'(dm_rdata == wax_r);
          svm_pkg::OP_NE:  wax_nxt = 64'(dm_rdata != wax_r);
          svm_pkg::OP_LT:  wax_nxt = 64'($signed(dm_rdata) <  $signed(wax_r));
          svm_pkg::OP_LE:  wax_nxt = 64'($signed(dm_rdata) <= $signed(wax_r));
          svm_pkg::OP_GT:  wax_nxt = 64'($signed(dm_rdata) >  $signed(wax_r));
          svm_pkg::OP_GE:  wax_nxt = 64'($signed(dm_rdata) >= $signed(wax_r));
          svm_pkg::OP_ADD: wax_nxt = dm_rdata + wax_r;
          svm_pkg::OP_SUB: wax_nxt = dm_rdata - wax_r;
          svm_pkg::OP_DIV, svm_pkg::OP_MOD: begin
            if (divz) stat_nxt = svm_pkg::STAT_DIVZ;
          end
          default: ;
        endcase
      end
      svm_pkg::S_POP2: begin
        if (dm_rdata >= CODE_LIM) begin
          stat_nxt = svm_pkg::STAT_FAULT;
        end else begin
          wbp_nxt = wl_r[15:0];
          wpc_nxt = dm_rdata[PCW-1:0];
        end
      end
      svm_pkg::S_TOP: begin
        if (op_r == svm_pkg::OP_EXIT) begin
          exit_nxt = dm_rdata;
          stat_nxt = svm_pkg::STAT_EXIT;
        end else begin
          wax_nxt = dm_rdata;
        end
      end
      svm_pkg::S_LOAD0: begin
        word = dm_rdata >> {wax_r[2:0], 3'b000};
        if (op_r == svm_pkg::OP_LC) begin
          wax_nxt = {{56{word[7]}}, word[7:0]};
        end else if (ld_split) begin
          wl_nxt  = dm_rdata;
          dm_re   = 1'b1;
          dm_addr = widx(wax_r) + DW'(1);
        end else begin
          wax_nxt = {{32{word[31]}}, word[31:0]};
        end
      end
      svm_pkg::S_LOAD1: begin
        lanes   = {dm_rdata, wl_r} >> {wax_r[2:0], 3'b000};
        wax_nxt = {{32{lanes[31]}}, lanes[31:0]};
      end
      svm_pkg::S_STORE1: begin
        // wl_r holds the store byte address
        lanes    = {64'd0, wax_r} << {wl_r[2:0], 3'b000};
        be16     = lane_be(wl_r[2:0], 1'b1);
        dm_we    = 1'b1;
        dm_addr  = widx(wl_r) + DW'(1);
        dm_be    = be16[15:8];
        dm_wdata = lanes[127:64];
      end
      svm_pkg::S_MULDIV: begin
        if (md_rsp.done) wax_nxt = md_rsp.result;
      end
      default: ;
    endcase

    // commit or halt as an instruction finishes
    if ((state_r != svm_pkg::S_IDLE) && (state_r != svm_pkg::S_RESP) &&
        (state_r != svm_pkg::S_HOSTRD) && (state_nxt == svm_pkg::S_RESP)) begin
      case (stat_nxt)
        svm_pkg::STAT_OK: begin
          pc_nxt  = wpc_nxt;
          acc_nxt = wax_nxt;
          sp_nxt  = wsp_nxt;
          bp_nxt  = wbp_nxt;
        end
        svm_pkg::STAT_EXIT: begin
          pc_nxt   = wpc_nxt;
          halt_nxt = 1'b1;
        end
        default: halt_nxt = 1'b1;
      endcase
    end

    if (cfg_wr) begin
      if (paddr[2]) begin
        stop_nxt = pwdata[15:0];
        sp_nxt   = pwdata[15:0];
        bp_nxt   = pwdata[15:0];
      end else begin
        start_nxt = pwdata[9:0];
        pc_nxt    = PCW'(pwdata[9:0]);
        halt_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svm_pkg::S_IDLE;
      start_r <= '0;
      stop_r  <= 16'h8000;
      pc_r    <= '0;
      acc_r   <= '0;
      sp_r    <= 16'h8000;
      bp_r    <= 16'h8000;
      halt_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      stop_r  <= stop_nxt;
      pc_r    <= pc_nxt;
      acc_r   <= acc_nxt;
      sp_r    <= sp_nxt;
      bp_r    <= bp_nxt;
      halt_r  <= halt_nxt;
    end
    op_r   <= op_nxt;
    req_r  <= req_nxt;
    wpc_r  <= wpc_nxt;
    wax_r  <= wax_nxt;
    wsp_r  <= wsp_nxt;
    wbp_r  <= wbp_nxt;
    wl_r   <= wl_nxt;
    stat_r <= stat_nxt;
    exit_r <= exit_nxt;
    rd_r   <= rd_nxt;
  end

  // ---- ports ----
  assign in_stall  = (state_r != svm_pkg::S_IDLE);
  assign out_valid = (state_r == svm_pkg::S_RESP);
  assign out_data.status          = stat_r;
  assign out_data.program_counter = pc_r[9:0];
  assign out_data.accumulator     = acc_r;
  assign out_data.stack_pointer   = sp_r;
  assign out_data.exit_code       = exit_r;
  // latched request type gates read data
  assign out_data.read_data       = (req_r.req_type == svm_pkg::REQ_READ) ? rd_r : 64'd0;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(stop_r) : 32'(start_r);

`ifndef ASSERT_OFF
  a_halted_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.req_type == svm_pkg::REQ_EXEC) && halt_r)
      |=> (stat_r == svm_pkg::STAT_HALT) && out_valid)
    else $error("halted machine executed an instruction");
  a_md_done: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> (state_r == svm_pkg::S_MULDIV))
    else $error("multiply/divide result outside its wait state");
  a_trap_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((stat_r == svm_pkg::STAT_DIVZ) || (stat_r == svm_pkg::STAT_BADOP) ||
                   (stat_r == svm_pkg::STAT_EXIT))) |-> halt_r)
    else $error("trap or exit left machine running");
`endif

endmodule

/* tb/stack_vm_step_test.sv */
// stack_vm_step_test: self-checking testbench for the stack virtual machine step block.
// Builds requests and their expected results from its own machine model.
// Depends on svm_pkg and stack_vm_step.
module stack_vm_step_test;
  import svm_pkg::*;

  localparam int CODE_N = 1024;
  localparam int DATA_N = 4096;
  localparam int ITEM_GOAL = 1750;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] ADDR_START = 3'd0;   // start_address register
  localparam logic [2:0] ADDR_STACK = 3'd4;   // stack_top register

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  stack_vm_step u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Machine model: memories with written flags, architectural registers.
  bit [63:0] vm_code[CODE_N];
  bit        vm_code_ok[CODE_N];
  bit [63:0] vm_data[DATA_N];
  bit        vm_data_ok[DATA_N];
  int unsigned vm_pc, vm_sp, vm_bp;
  bit [63:0] vm_acc;
  bit        vm_halted;

  // First never-written entry touched by a trial execute.
  bit          miss_hit;
  bit          miss_is_code;
  int unsigned miss_idx;

  in_item_t  request_fifo[$];
  out_item_t pending_results[$];

  int  sent_cnt;
  int  out_cnt;
  int  err_cnt;
  int  status_seen[8];
  int  cycle_cnt;
  int  idle_cycles;
  int  hold_left;
  bit  hold_done;
  bit  in_fire;
  bit  run_done;
  wire calm = (cycle_cnt >= 3000) && (cycle_cnt < 6000);

  // ---------------------------------------------------------------
  // Model primitives
  // ---------------------------------------------------------------
  function automatic bit [63:0] code_rd(int unsigned a);
    if (!vm_code_ok[a] && !miss_hit) begin
      miss_hit = 1; miss_is_code = 1; miss_idx = a;
    end
    return vm_code[a];
  endfunction

  function automatic bit [63:0] data_rd(int unsigned w);
    if (!vm_data_ok[w] && !miss_hit) begin
      miss_hit = 1; miss_is_code = 0; miss_idx = w;
    end
    return vm_data[w];
  endfunction

  function automatic bit [7:0] byte_rd(bit [63:0] a);
    bit [63:0] w;
    w = data_rd(int'(a >> 3));
    return 8'(w >> (a[2:0] * 8));
  endfunction

  function automatic void byte_wr(bit [63:0] a, bit [7:0] b, bit dry);
    bit [63:0] w;
    int sh;
    sh = a[2:0] * 8;
    w = data_rd(int'(a >> 3));
    if (!dry) vm_data[a >> 3] = (w & ~(64'hFF << sh)) | (64'(b) << sh);
  endfunction

  function automatic bit span_ok(bit [63:0] a, int n);
    return a < 64'd32768 && (64'd32768 - a) >= 64'(n);
  endfunction

  function automatic bit fetch_word(inout int unsigned p, output bit [63:0] v);
    v = 0;
    if (p >= CODE_N) return 0;
    v = code_rd(p);
    p++;
    return 1;
  endfunction

  function automatic bit pop_word(inout int unsigned s, output bit [63:0] v);
    v = 0;
    if ((s >> 3) >= DATA_N) return 0;
    v = data_rd(s >> 3);
    s = (s + 8) & 32'hFFFF;
    return 1;
  endfunction

  function automatic bit push_word(inout int unsigned s, input bit [63:0] v, input bit dry);
    int unsigned n;
    n = (s - 8) & 32'hFFFF;
    if ((n >> 3) >= DATA_N) return 0;
    if (!dry) begin
      vm_data[n >> 3] = v;
      vm_data_ok[n >> 3] = 1;
    end
    s = n;
    return 1;
  endfunction

  // One instruction. With dry set nothing is committed; used to find
  // unwritten entries the instruction would touch.
  function automatic status_t run_one(input bit dry, output bit [63:0] xc);
    int unsigned pc, sp, bp;
    bit [63:0] ax, opw, v, l, r;
    int n;
    opcode_t op;
    pc = vm_pc; sp = vm_sp; bp = vm_bp; ax = vm_acc;
    xc = 0; v = 0; l = 0; r = 0;
    if (!fetch_word(pc, opw)) return STAT_FAULT;
    if (opw > 64'd35) begin
      xc = '1;
      return STAT_BADOP;
    end
    op = opcode_t'(opw[5:0]);
    if (op == OP_OPEN || (op >= OP_READ && op <= OP_MCMP)) return STAT_UNSUP;
    case (op)
      OP_IMM: if (!fetch_word(pc, ax)) return STAT_FAULT;
      OP_LC: begin
        if (!span_ok(ax, 1)) return STAT_FAULT;
        r = 64'(byte_rd(ax));
        ax = {{56{r[7]}}, r[7:0]};
      end
      OP_LI: begin
        if (!span_ok(ax, 4)) return STAT_FAULT;
        for (int i = 0; i < 4; i++) r |= 64'(byte_rd(ax + i)) << (8 * i);
        ax = {{32{r[31]}}, r[31:0]};
      end
      OP_SC, OP_SI: begin
        n = (op == OP_SC) ? 1 : 4;
        if (!pop_word(sp, v)) return STAT_FAULT;
        if (!span_ok(v, n)) return STAT_FAULT;
        for (int i = 0; i < n; i++) byte_wr(v + i, 8'(ax >> (8 * i)), dry);
      end
      OP_PUSH: if (!push_word(sp, ax, dry)) return STAT_FAULT;
      OP_JMP, OP_JEZ, OP_JNZ, OP_CALL: begin
        if (!fetch_word(pc, v)) return STAT_FAULT;
        // conditional branches not taken just step past the target word
        if (!((op == OP_JEZ && ax != 0) || (op == OP_JNZ && ax == 0))) begin
          if (v >= CODE_N) return STAT_FAULT;
          if (op == OP_CALL && !push_word(sp, 64'(pc), dry)) return STAT_FAULT;
          pc = int'(v);
        end
      end
      OP_ADJ: begin
        if (!fetch_word(pc, v)) return STAT_FAULT;
        sp = int'((64'(sp) + v * 8) & 64'hFFFF);
      end
      OP_ENT: begin
        if (!fetch_word(pc, v)) return STAT_FAULT;
        if (!push_word(sp, 64'(bp), dry)) return STAT_FAULT;
        bp = sp;
        sp = int'((64'(sp) - v * 8) & 64'hFFFF);
      end
      OP_LEV: begin
        sp = bp;
        if (!pop_word(sp, l) || !pop_word(sp, v)) return STAT_FAULT;
        if (v >= CODE_N) return STAT_FAULT;
        bp = int'(l[15:0]);
        pc = int'(v);
      end
      OP_LAA: begin
        if (!fetch_word(pc, v)) return STAT_FAULT;
        ax = 64'(bp) + v * 8;
      end
      OP_CLOS: begin
        if ((sp >> 3) >= DATA_N) return STAT_FAULT;
        ax = data_rd(sp >> 3);
      end
      OP_EXIT: begin
        if ((sp >> 3) >= DATA_N) return STAT_FAULT;
        xc = data_rd(sp >> 3);
        if (!dry) vm_pc = pc;
        return STAT_EXIT;
      end
      default: begin
        // binary ops: left operand comes off the stack
        if (!pop_word(sp, l)) return STAT_FAULT;
        case (op)
          OP_OR:  ax = l | ax;
          OP_XOR: ax = l ^ ax;
          OP_AND: ax = l & ax;
          OP_EQ:  ax = 64'(l == ax);
          OP_NE:  ax = 64'(l != ax);
          OP_LT:  ax = 64'($signed(l) < $signed(ax));
          OP_LE:  ax = 64'($signed(l) <= $signed(ax));
          OP_GT:  ax = 64'($signed(l) > $signed(ax));
          OP_GE:  ax = 64'($signed(l) >= $signed(ax));
          OP_ADD: ax = l + ax;
          OP_SUB: ax = l - ax;
          OP_MUL: ax = l * ax;
          default: begin
            if (ax == 0) return STAT_DIVZ;
            // divisor of minus one: negate / zero, so min / -1 stays min
            if (ax == '1) ax = (op == OP_DIV) ? -l : 64'd0;
            else if (op == OP_DIV) ax = $signed(l) / $signed(ax);
            else ax = $signed(l) % $signed(ax);
          end
        endcase
      end
    endcase
    if (!dry) begin
      vm_pc = pc; vm_acc = ax; vm_sp = sp; vm_bp = bp;
    end
    return STAT_OK;
  endfunction

  // Apply one request to the model and return the result it must produce.
  function automatic out_item_t vm_step(in_item_t it);
    out_item_t o;
    status_t st;
    bit [63:0] xc, rd;
    st = STAT_OK; xc = 0; rd = 0;
    case (req_t'(it.req_type))
      REQ_CODE: begin
        if (it.address < CODE_N) begin
          vm_code[it.address] = it.value;
          vm_code_ok[it.address] = 1;
        end else st = STAT_FAULT;
      end
      REQ_WRITE: begin
        vm_data[it.address >> 3] = it.value;
        vm_data_ok[it.address >> 3] = 1;
      end
      REQ_READ: rd = vm_data[it.address >> 3];
      default: begin
        if (vm_halted) st = STAT_HALT;
        else begin
          st = run_one(0, xc);
          if (st != STAT_OK) vm_halted = 1;
        end
      end
    endcase
    o.status = st;
    o.program_counter = vm_pc[9:0];
    o.accumulator = vm_acc;
    o.stack_pointer = vm_sp[15:0];
    o.exit_code = xc;
    o.read_data = rd;
    return o;
  endfunction

  function automatic void vm_config(logic [2:0] a, logic [31:0] d);
    if (a == ADDR_START) begin
      vm_pc = d & 32'h3FF;
      vm_halted = 0;
    end else begin
      vm_sp = d & 32'hFFFF;
      vm_bp = vm_sp;
    end
  endfunction

  // ---------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------
  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [63:0] corner64();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return 64'd1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'h7FFF_FFFF_FFFF_FFFF;
      default: return rand64();
    endcase
  endfunction

  function automatic void send(req_t kind, int unsigned addr, bit [63:0] val);
    in_item_t it;
    it.req_type = kind;
    it.address = addr[14:0];
    it.value = val;
    pending_results.push_back(vm_step(it));
    request_fifo.push_back(it);
    sent_cnt++;
  endfunction

  function automatic bit [63:0] pick_opcode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 64'($urandom_range(36, 255));
    if (r == 2) return rand64() | 64'h8000_0000_0000_0000;
    if (r < 5) begin
      case ($urandom_range(0, 5))
        0: return OP_OPEN;
        1: return OP_READ;
        2: return OP_PRTF;
        3: return OP_MALC;
        4: return OP_MSET;
        default: return OP_MCMP;
      endcase
    end
    r = $urandom_range(0, 29);
    if (r == 28) return OP_CLOS;
    if (r == 29) return OP_EXIT;
    return 64'(r);
  endfunction

  // Stack slots get mostly plausible return targets and data addresses.
  function automatic bit [63:0] fill_value();
    case ($urandom_range(0, 3))
      0, 1: return 64'($urandom_range(0, CODE_N - 1));
      2: return 64'($urandom_range(0, 32767));
      default: return corner64();
    endcase
  endfunction

  function automatic bit [63:0] pick_operand(bit [63:0] opw);
    bit signed [63:0] s;
    case (opw)
      OP_JMP, OP_JEZ, OP_JNZ, OP_CALL:
        return ($urandom_range(0, 99) < 97) ? 64'($urandom_range(0, CODE_N - 1)) : rand64();
      OP_ADJ, OP_ENT: begin
        s = int'($urandom_range(0, 8)) - 4;
        return s;
      end
      OP_LAA: begin
        s = int'($urandom_range(0, 16)) - 8;
        return s;
      end
      OP_IMM:
        return ($urandom_range(0, 9) < 3) ? 64'($urandom_range(0, 32767)) : corner64();
      default: return rand64();
    endcase
  endfunction

  // Write whatever never-written entries the next instruction would read,
  // then issue the execute request.
  function automatic void exec_now();
    bit [63:0] xc;
    if (!vm_halted) begin
      for (int k = 0; k < 16; k++) begin
        miss_hit = 0;
        void'(run_one(1, xc));
        if (!miss_hit) break;
        if (miss_is_code) send(REQ_CODE, miss_idx, pick_opcode());
        else send(REQ_WRITE, miss_idx * 8 + $urandom_range(0, 7), fill_value());
      end
    end
    send(REQ_EXEC, $urandom_range(0, 32767), rand64());
  endfunction

  function automatic void run_instr(bit [63:0] opw, bit [63:0] arg);
    send(REQ_CODE, vm_pc, opw);
    if (vm_pc + 1 < CODE_N) send(REQ_CODE, vm_pc + 1, arg);
    exec_now();
  endfunction

  function automatic void random_exec();
    bit [63:0] opw;
    if ($urandom_range(0, 99) < 70 || !vm_code_ok[vm_pc]) begin
      opw = pick_opcode();
      // byte/word loads mostly get a usable address first
      if ((opw == OP_LC || opw == OP_LI) && $urandom_range(0, 9) < 7)
        run_instr(OP_IMM, 64'($urandom_range(0, 32767)));
      if (!vm_halted) run_instr(opw, pick_operand(opw));
    end else exec_now();
  endfunction

  function automatic void host_read();
    int unsigned w;
    for (int k = 0; k < 32; k++) begin
      w = $urandom_range(0, DATA_N - 1);
      if (vm_data_ok[w]) begin
        send(REQ_READ, w * 8 + $urandom_range(0, 7), rand64());
        break;
      end
    end
  endfunction

  // ---------------------------------------------------------------
  // Config writes, only with nothing in flight
  // ---------------------------------------------------------------
  task automatic cfg_write(logic [2:0] a, logic [31:0] d);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= a; pwdata <= d;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    vm_config(a, d);
  endtask

  task automatic restart();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      case ($urandom_range(0, 3))
        0: cfg_write(ADDR_STACK, 32'd0);
        1: cfg_write(ADDR_STACK, 32'd32768);
        default: cfg_write(ADDR_STACK, 32'($urandom_range(0, 4096) * 8));
      endcase
    end
    r = $urandom_range(0, 9);
    cfg_write(ADDR_START, (r == 0) ? 32'd0 : (r == 1) ? 32'd1023 : 32'($urandom_range(0, 1023)));
  endtask

  // ---------------------------------------------------------------
  // Clock, reset and the stimulus sequence
  // ---------------------------------------------------------------
  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    vm_pc = 0; vm_acc = 0; vm_sp = 32768; vm_bp = 32768; vm_halted = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: register extremes, address extremes, host faults.
    cfg_write(ADDR_STACK, 32'd32768);
    cfg_write(ADDR_START, 32'd0);
    send(REQ_CODE, 1023, 64'h7FFF_FFFF_FFFF_FFFF);
    send(REQ_CODE, 1024, rand64());               // code load beyond memory
    send(REQ_CODE, 32767, 64'h8000_0000_0000_0000);
    send(REQ_WRITE, 0, 64'h8000_0000_0000_0000);
    send(REQ_WRITE, 32767, '1);
    send(REQ_READ, 7, 0);
    send(REQ_READ, 32760, '1);
    // most negative / -1 and its remainder
    run_instr(OP_IMM, 64'h8000_0000_0000_0000);
    run_instr(OP_PUSH, 0);
    run_instr(OP_IMM, '1);
    run_instr(OP_DIV, 0);
    run_instr(OP_PUSH, 0);
    run_instr(OP_IMM, '1);
    run_instr(OP_MOD, 0);
    // divide by zero, then an execute while halted
    run_instr(OP_PUSH, 0);
    run_instr(OP_DIV, 0);
    exec_now();
    restart();
    // every opcode once plus a bad one
    for (int op = 0; op <= 36; op++) begin
      if (vm_halted) restart();
      run_instr(op == 36 ? '1 : 64'(op), pick_operand(64'(op)));
    end
    restart();

    // Random part: mostly instruction flow, some host traffic.
    while (sent_cnt < ITEM_GOAL) begin
      case ($urandom_range(0, 99)) inside
        [0:6]:   send(REQ_WRITE, $urandom_range(0, 32767), corner64());
        [7:12]:  host_read();
        [13:15]: send(REQ_CODE, $urandom_range(0, 32767), pick_opcode());
        [16:17]: restart();
        default: begin
          if (vm_halted) begin
            if ($urandom_range(0, 9) < 3) exec_now();
            else restart();
          end else random_exec();
        end
      endcase
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    run_done = 1;
    $display("Checked %0d results: %0d ok, %0d exit, %0d div-zero, %0d unsupported,",
             out_cnt, status_seen[STAT_OK], status_seen[STAT_EXIT], status_seen[STAT_DIVZ],
             status_seen[STAT_UNSUP]);
    $display("  %0d bad opcode, %0d halted, %0d fault; %0d mismatches",
             status_seen[STAT_BADOP], status_seen[STAT_HALT], status_seen[STAT_FAULT], err_cnt);
    if (err_cnt == 0) begin
      $display("stack_vm_step verification clean");
    end else begin
      $display("stack_vm_step verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------
  // Driver: requests change at the falling edge; a held item stays put
  // until its transfer.
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (in_valid && !in_fire) begin
      // still waiting for this transfer
    end else if (request_fifo.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
      in_valid <= 1;
      in_data <= request_fifo.pop_front();
    end else begin
      in_valid <= 0;
    end
  end

  // Result side stall: random, quiet during the calm window, and one long
  // hold-off so the block backs up onto its input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else if (!hold_done && out_cnt >= 300) begin
      hold_done <= 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end
  end

  // ---------------------------------------------------------------
  // Monitor and watchdog, sampled at the rising edge
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    bit bad;
    cycle_cnt <= cycle_cnt + 1;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;

    if (rst_n && out_valid && !out_stall) begin
      out_cnt <= out_cnt + 1;
      status_seen[out_data.status] <= status_seen[out_data.status] + 1;
      if (pending_results.size() == 0) begin
        if (err_cnt < 10) $display("ERROR: result with nothing outstanding, status %0d",
                                   out_data.status);
        err_cnt <= err_cnt + 1;
      end else begin
        want = pending_results.pop_front();
        bad = (out_data.status !== want.status)
           || (out_data.program_counter !== want.program_counter)
           || (out_data.accumulator !== want.accumulator)
           || (out_data.stack_pointer !== want.stack_pointer)
           || (out_data.exit_code !== want.exit_code)
           || (out_data.read_data !== want.read_data);
        if (bad) begin
          if (err_cnt < 10) begin
            $display("ERROR: result %0d mismatch", out_cnt);
            $display("  status  exp %0d got %0d, pc exp %0d got %0d, sp exp %h got %h",
                     want.status, out_data.status, want.program_counter,
                     out_data.program_counter, want.stack_pointer, out_data.stack_pointer);
            $display("  acc  exp %h got %h", want.accumulator, out_data.accumulator);
            $display("  exit exp %h got %h", want.exit_code, out_data.exit_code);
            $display("  rd   exp %h got %h", want.read_data, out_data.read_data);
          end
          err_cnt <= err_cnt + 1;
        end
      end
    end

    if (!run_done && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("stack_vm_step verification failed");
      $finish;
    end
  end

endmodule
